// File: hw/rtl/fsac_pkg.sv
// Shared types and constants for the Forth stack ALU core.
package fsac_pkg;

  localparam int DATA_DEPTH   = 64;
  localparam int RETURN_DEPTH = 64;
  localparam int DATA_AW      = $clog2(DATA_DEPTH);
  localparam int RET_AW       = $clog2(RETURN_DEPTH);
  localparam int DCNT_W       = $clog2(DATA_DEPTH + 1);
  localparam int RCNT_W       = $clog2(RETURN_DEPTH + 1);
  localparam int WORD_W       = 32;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_LIT = 6'd1, OP_TO_R = 6'd2, OP_R_FROM = 6'd3, OP_R_FETCH = 6'd4,
    OP_DUP = 6'd5, OP_DROP = 6'd6, OP_OVER = 6'd7, OP_SWAP = 6'd8, OP_ROT = 6'd9,
    OP_PICK = 6'd10, OP_DUP2 = 6'd11, OP_DROP2 = 6'd12, OP_OVER2 = 6'd13,
    OP_SWAP2 = 6'd14, OP_ADD = 6'd15, OP_MUL = 6'd16, OP_SUB = 6'd17, OP_DIV = 6'd18,
    OP_MOD = 6'd19, OP_MULDIV = 6'd20, OP_DIVMOD = 6'd21, OP_MULDIVMOD = 6'd22,
    OP_AND = 6'd23, OP_OR = 6'd24, OP_XOR = 6'd25, OP_ABS = 6'd26, OP_NEG = 6'd27,
    OP_MAX = 6'd28, OP_MIN = 6'd29, OP_SHL = 6'd30, OP_SHR = 6'd31, OP_INC = 6'd32,
    OP_DEC = 6'd33, OP_ZEQ = 6'd34, OP_ZLT = 6'd35, OP_ZGT = 6'd36, OP_EQ = 6'd37,
    OP_GT = 6'd38, OP_LT = 6'd39, OP_NE = 6'd40, OP_GE = 6'd41, OP_LE = 6'd42
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RC, S_MUL, S_DST, S_DIV, S_FIN, S_WR, S_OUT
  } state_t;

endpackage

// File: hw/rtl/fsac_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module fsac_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fsac_pkg::WORD_W-1:0] dividend,
  input  logic [fsac_pkg::WORD_W-1:0] divisor,
  output logic                      done,
  output logic [fsac_pkg::WORD_W-1:0] quotient,
  output logic [fsac_pkg::WORD_W-1:0] remainder
);
  import fsac_pkg::*;

  logic                busy_r, done_r, negq_r, negr_r;
  logic [4:0]          cnt_r;
  logic [WORD_W:0]     p_r;
  logic [WORD_W-1:0]   qd_r, d_r;
  logic [WORD_W:0]     p_sh, p_sub;

  assign p_sh  = {p_r[WORD_W-1:0], qd_r[WORD_W-1]};
  assign p_sub = p_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        p_r    <= '0;
        qd_r   <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
        d_r    <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
        negq_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        negr_r <= dividend[WORD_W-1];
      end else if (busy_r) begin
        if (!p_sub[WORD_W]) begin
          p_r  <= p_sub;
          qd_r <= {qd_r[WORD_W-2:0], 1'b1};
        end else begin
          p_r  <= p_sh;
          qd_r <= {qd_r[WORD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = negq_r ? (~qd_r + 1'b1) : qd_r;
  assign remainder = negr_r ? (~p_r[WORD_W-1:0] + 1'b1) : p_r[WORD_W-1:0];

endmodule

// File: hw/rtl/forth_stack_alu_core.sv
// Forth stack ALU core: top register, data and return stack memories, primitive sequencer.
// One primitive per request, one result per request. The top of the data stack lives in a
// register; the entries below it and the return stack live in memories that are read
// through a register. A request passes accept, a read-address and a read-capture step per
// stack read (up to 3), a product step and a division as needed, a finish step and a
// write step per data memory write (up to 3); star-slash-mod is longest, errors skip to
// output. A finished result waits in the output register while the next request runs.
module forth_stack_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_operation,
  input  logic signed [31:0] in_literal_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_top_value,
  output logic [6:0]  out_data_depth,
  output logic [6:0]  out_return_depth,
  output logic [1:0]  out_status
);
  import fsac_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, in_op;
  stat_t  st_r, dec_st;
  logic [WORD_W-1:0] top_r, lit_r, prod_r, dmem_q, rmem_q;
  logic [DCNT_W-1:0] dcnt_r;
  logic [RCNT_W-1:0] rcnt_r;
  logic [WORD_W-1:0] b_r [0:2];
  logic [1:0]        k_r, rdn_r, dec_rdn, nw_r, wi_r;
  logic [DATA_AW-1:0] wa_r [0:2];
  logic [WORD_W-1:0]  wd_r [0:2];
  logic [WORD_W-1:0] dmem [0:DATA_DEPTH-1];
  logic [WORD_W-1:0] rmem [0:RETURN_DEPTH-1];
  logic [DATA_AW-1:0] rd_addr;
  logic [DCNT_W-1:0]  rd_cnt;
  logic               out_free, is_mul, is_div, div_start, div_done;
  logic [WORD_W-1:0]  div_q, div_rem, div_a;
  logic [1:0]         dec_below, dec_grow;
  logic [WORD_W-1:0]  top_nxt;
  logic [DCNT_W-1:0]  dcnt_nxt;
  logic [RCNT_W-1:0]  rcnt_nxt;
  logic [1:0]         nw_nxt;
  logic [DCNT_W-1:0]  wc_nxt [0:2];
  logic [WORD_W-1:0]  wd_nxt [0:2];
  logic               r_we;
  logic signed [WORD_W-1:0] sa, stp;

  assign in_op    = op_t'(in_operation);
  assign out_free = !out_valid || !out_stall;
  assign is_mul   = (op_r == OP_MUL) || (op_r == OP_MULDIV) || (op_r == OP_MULDIVMOD);
  assign is_div   = (op_r == OP_DIV) || (op_r == OP_MOD) || (op_r == OP_DIVMOD) ||
                    (op_r == OP_MULDIV) || (op_r == OP_MULDIVMOD);

  // decode requirements and status at accept
  always_comb begin
    dec_below = 2'd0;
    dec_grow  = 2'd0;
    dec_rdn   = 2'd0;
    dec_st    = ST_OK;
    case (in_op) inside
      OP_LIT, OP_DUP:           begin dec_grow = 2'd1; end
      OP_DROP, OP_SWAP:         begin dec_below = 2'd1; dec_rdn = 2'd1; end
      OP_OVER:                  begin dec_below = 2'd1; dec_grow = 2'd1; dec_rdn = 2'd1; end
      OP_ROT, OP_DROP2:         begin dec_below = 2'd2; dec_rdn = 2'd2; end
      OP_DUP2:                  begin dec_below = 2'd1; dec_grow = 2'd2; dec_rdn = 2'd1; end
      OP_OVER2:                 begin dec_below = 2'd3; dec_grow = 2'd2; dec_rdn = 2'd3; end
      OP_SWAP2:                 begin dec_below = 2'd3; dec_rdn = 2'd3; end
      OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD, OP_DIVMOD, OP_AND, OP_OR, OP_XOR,
      OP_MAX, OP_MIN, OP_EQ, OP_GT, OP_LT, OP_NE, OP_GE, OP_LE:
                                begin dec_below = 2'd1; dec_rdn = 2'd1; end
      OP_MULDIV, OP_MULDIVMOD:  begin dec_below = 2'd2; dec_rdn = 2'd2; end
      default: ;
    endcase
    if (dcnt_r < DCNT_W'(dec_below))
      dec_st = ST_UNDER;
    else if ({1'b0, dcnt_r} + (DCNT_W+1)'(dec_grow) > (DCNT_W+1)'(DATA_DEPTH))
      dec_st = ST_OVER;
    else if ((in_op == OP_DIV || in_op == OP_MOD || in_op == OP_DIVMOD ||
              in_op == OP_MULDIV || in_op == OP_MULDIVMOD) && top_r == '0)
      dec_st = ST_DIVZ;
    case (in_op) inside
      OP_TO_R: begin
        dec_rdn = 2'd1;
        if (dcnt_r == '0) dec_st = ST_UNDER;
        else if ({1'b0, rcnt_r} >= (RCNT_W+1)'(RETURN_DEPTH)) dec_st = ST_OVER;
        else dec_st = ST_OK;
      end
      OP_R_FROM, OP_R_FETCH: begin
        dec_rdn = 2'd1;
        if (rcnt_r == '0) dec_st = ST_UNDER;
        else if ({1'b0, dcnt_r} + 1'b1 > (DCNT_W+1)'(DATA_DEPTH)) dec_st = ST_OVER;
        else dec_st = ST_OK;
      end
      OP_PICK: begin
        dec_rdn = 2'd1;
        if (top_r[WORD_W-1] || top_r >= WORD_W'(dcnt_r)) dec_st = ST_UNDER;
        else dec_st = ST_OK;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        if (dec_st != ST_OK) state_nxt = S_OUT;
        else if (dec_rdn != 2'd0) state_nxt = S_RA;
        else state_nxt = S_FIN;
      end
      S_RA: state_nxt = S_RC;
      S_RC: begin
        if (k_r + 2'd1 != rdn_r) state_nxt = S_RA;
        else if (is_mul) state_nxt = S_MUL;
        else if (is_div) state_nxt = S_DST;
        else state_nxt = S_FIN;
      end
      S_MUL: state_nxt = (op_r == OP_MUL) ? S_FIN : S_DST;
      S_DST: state_nxt = S_DIV;
      S_DIV: if (div_done) state_nxt = S_FIN;
      S_FIN: state_nxt = (nw_nxt != 2'd0) ? S_WR : S_OUT;
      S_WR:  if (wi_r + 2'd1 == nw_r) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    div_start = (state_r == S_DST);
    r_we      = (state_r == S_FIN) && (op_r == OP_TO_R);
  end

  assign rd_cnt  = (op_r == OP_PICK) ? (dcnt_r - 1'b1 - top_r[DCNT_W-1:0])
                                      : (dcnt_r - 1'b1 - DCNT_W'(k_r));
  assign rd_addr = rd_cnt[DATA_AW-1:0];
  assign div_a   = (op_r == OP_MULDIV || op_r == OP_MULDIVMOD) ? prod_r : b_r[0];
  assign sa      = $signed(b_r[0]);
  assign stp     = $signed(top_r);

  fsac_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (top_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // result of the primitive
  always_comb begin
    top_nxt  = top_r;
    dcnt_nxt = dcnt_r;
    rcnt_nxt = rcnt_r;
    nw_nxt   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      wc_nxt[i] = dcnt_r;
      wd_nxt[i] = top_r;
    end
    case (op_r)
      OP_LIT:    begin nw_nxt = 2'd1; top_nxt = lit_r; dcnt_nxt = dcnt_r + 1'b1; end
      OP_TO_R:   begin top_nxt = b_r[0]; dcnt_nxt = dcnt_r - 1'b1; rcnt_nxt = rcnt_r + 1'b1; end
      OP_R_FROM: begin
        nw_nxt = 2'd1; top_nxt = b_r[0]; dcnt_nxt = dcnt_r + 1'b1; rcnt_nxt = rcnt_r - 1'b1;
      end
      OP_R_FETCH, OP_OVER: begin nw_nxt = 2'd1; top_nxt = b_r[0]; dcnt_nxt = dcnt_r + 1'b1; end
      OP_DUP:    begin nw_nxt = 2'd1; dcnt_nxt = dcnt_r + 1'b1; end
      OP_DROP:   begin top_nxt = b_r[0]; dcnt_nxt = dcnt_r - 1'b1; end
      OP_SWAP:   begin nw_nxt = 2'd1; wc_nxt[0] = dcnt_r - 1'b1; top_nxt = b_r[0]; end
      OP_ROT: begin
        nw_nxt = 2'd2; wc_nxt[0] = dcnt_r - 2'd2; wd_nxt[0] = b_r[0];
        wc_nxt[1] = dcnt_r - 1'b1; top_nxt = b_r[1];
      end
      OP_PICK:   top_nxt = b_r[0];
      OP_DUP2: begin
        nw_nxt = 2'd2; wc_nxt[1] = dcnt_r + 1'b1; wd_nxt[1] = b_r[0];
        dcnt_nxt = dcnt_r + 2'd2;
      end
      OP_DROP2:  begin top_nxt = b_r[1]; dcnt_nxt = dcnt_r - 2'd2; end
      OP_OVER2: begin
        nw_nxt = 2'd2; wc_nxt[1] = dcnt_r + 1'b1; wd_nxt[1] = b_r[2];
        top_nxt = b_r[1]; dcnt_nxt = dcnt_r + 2'd2;
      end
      OP_SWAP2: begin
        nw_nxt = 2'd3;
        wc_nxt[0] = dcnt_r - 2'd3; wd_nxt[0] = b_r[0];
        wc_nxt[1] = dcnt_r - 2'd2;
        wc_nxt[2] = dcnt_r - 1'b1; wd_nxt[2] = b_r[2];
        top_nxt = b_r[1];
      end
      OP_ADD: begin top_nxt = b_r[0] + top_r; dcnt_nxt = dcnt_r - 1'b1; end
      OP_MUL: begin top_nxt = prod_r; dcnt_nxt = dcnt_r - 1'b1; end
      OP_SUB: begin top_nxt = b_r[0] - top_r; dcnt_nxt = dcnt_r - 1'b1; end
      OP_DIV: begin top_nxt = div_q; dcnt_nxt = dcnt_r - 1'b1; end
      OP_MOD: begin top_nxt = div_rem; dcnt_nxt = dcnt_r - 1'b1; end
      OP_DIVMOD: begin
        nw_nxt = 2'd1; wc_nxt[0] = dcnt_r - 1'b1; wd_nxt[0] = div_rem; top_nxt = div_q;
      end
      OP_MULDIV: begin top_nxt = div_q; dcnt_nxt = dcnt_r - 2'd2; end
      OP_MULDIVMOD: begin
        nw_nxt = 2'd1; wc_nxt[0] = dcnt_r - 2'd2; wd_nxt[0] = div_rem;
        top_nxt = div_q; dcnt_nxt = dcnt_r - 1'b1;
      end
      OP_AND: begin top_nxt = b_r[0] & top_r; dcnt_nxt = dcnt_r - 1'b1; end
      OP_OR:  begin top_nxt = b_r[0] | top_r; dcnt_nxt = dcnt_r - 1'b1; end
      OP_XOR: begin top_nxt = b_r[0] ^ top_r; dcnt_nxt = dcnt_r - 1'b1; end
      OP_MAX: begin top_nxt = (sa < stp) ? top_r : b_r[0]; dcnt_nxt = dcnt_r - 1'b1; end
      OP_MIN: begin top_nxt = (stp < sa) ? top_r : b_r[0]; dcnt_nxt = dcnt_r - 1'b1; end
      OP_EQ:  begin top_nxt = {WORD_W{b_r[0] == top_r}}; dcnt_nxt = dcnt_r - 1'b1; end
      OP_GT:  begin top_nxt = {WORD_W{stp < sa}}; dcnt_nxt = dcnt_r - 1'b1; end
      OP_LT:  begin top_nxt = {WORD_W{sa < stp}}; dcnt_nxt = dcnt_r - 1'b1; end
      OP_NE:  begin top_nxt = {WORD_W{b_r[0] != top_r}}; dcnt_nxt = dcnt_r - 1'b1; end
      OP_GE:  begin top_nxt = {WORD_W{!(sa < stp)}}; dcnt_nxt = dcnt_r - 1'b1; end
      OP_LE:  begin top_nxt = {WORD_W{!(stp < sa)}}; dcnt_nxt = dcnt_r - 1'b1; end
      OP_ABS: top_nxt = top_r[WORD_W-1] ? (~top_r + 1'b1) : top_r;
      OP_NEG: top_nxt = ~top_r + 1'b1;
      OP_SHL: top_nxt = {top_r[WORD_W-2:0], 1'b0};
      OP_SHR: top_nxt = {top_r[WORD_W-1], top_r[WORD_W-1:1]};
      OP_INC: top_nxt = top_r + 1'b1;
      OP_DEC: top_nxt = top_r - 1'b1;
      OP_ZEQ: top_nxt = {WORD_W{top_r == '0}};
      OP_ZLT: top_nxt = {WORD_W{top_r[WORD_W-1]}};
      OP_ZGT: top_nxt = {WORD_W{(top_r != '0) && !top_r[WORD_W-1]}};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dmem_q <= dmem[rd_addr];
    rmem_q <= rmem[rcnt_r[RET_AW-1:0] - 1'b1];
    if (state_r == S_WR) dmem[wa_r[wi_r]] <= wd_r[wi_r];
    if (r_we) rmem[rcnt_r[RET_AW-1:0]] <= top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      top_r     <= '1;
      dcnt_r    <= '0;
      rcnt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r  <= in_op;
          lit_r <= in_literal_value;
          st_r  <= dec_st;
          rdn_r <= dec_rdn;
          k_r   <= 2'd0;
        end
        S_RC: begin
          if (op_r == OP_R_FROM || op_r == OP_R_FETCH) b_r[0] <= rmem_q;
          else b_r[k_r] <= dmem_q;
          k_r <= k_r + 2'd1;
        end
        S_MUL: prod_r <= (is_div ? b_r[1] : top_r) * b_r[0];
        S_FIN: begin
          top_r  <= top_nxt;
          dcnt_r <= dcnt_nxt;
          rcnt_r <= rcnt_nxt;
          nw_r   <= nw_nxt;
          wi_r   <= 2'd0;
          for (int i = 0; i < 3; i++) begin
            wa_r[i] <= wc_nxt[i][DATA_AW-1:0];
            wd_r[i] <= wd_nxt[i];
          end
        end
        S_WR: wi_r <= wi_r + 2'd1;
        S_OUT: if (out_free) begin
          out_top_value    <= top_r;
          out_data_depth   <= 7'(dcnt_r);
          out_return_depth <= 7'(rcnt_r);
          out_status       <= st_r;
        end
        default: ;
      endcase
      if (state_r == S_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
